// ----- src/ssfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfp_pkg
// Shared types, constants and helper functions for the scan sweep frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfp_pkg;

	// Sample slots and stepper phases
	localparam int SAMPLES     = 4;
	localparam int PHASES      = 4;
	localparam int SLOT_W      = $clog2(SAMPLES);
	localparam int PHASE_W     = $clog2(PHASES);

	// Field widths
	localparam int POS_W       = 6;
	localparam int SONAR_W     = 16;
	localparam int LIDAR_W     = 12;
	localparam int COIL_W      = 4;
	localparam int BYTE_W      = 8;
	localparam int FRAME_BYTES = 4;
	localparam int BIDX_W      = $clog2(FRAME_BYTES);

	// Configuration port
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	// Reset values and sweep limits
	localparam logic [POS_W-1:0] POS_RESET     = 6'd16;
	localparam logic [POS_W-1:0] POS_MAX_RESET = 6'd31;
	localparam logic [POS_W-1:0] POS_MIN       = 6'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 1'b0,
		REG_POSITION_MAX  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_MEASURE = 1'b0,
		FUNC_MOVE    = 1'b1
	} func_t;

	// Coil drive tables: full step for four phases, half step otherwise
	localparam logic [COIL_W-1:0] FULL_STEPS [4] = '{4'h1, 4'h8, 4'h2, 4'h4};
	localparam logic [COIL_W-1:0] HALF_STEPS [8] = '{4'h5, 4'h1, 4'h9, 4'h8,
		4'hA, 4'h2, 4'h6, 4'h4};

	// One frame ready for the serializer; bytes[0] goes out first
	typedef struct packed {
		logic [FRAME_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [COIL_W-1:0]                  coil;
	} frame_t;

	// Serializer status seen by the top level
	typedef struct packed {
		logic              busy;
		logic              free;
		logic [BIDX_W-1:0] idx;
	} fout_stat_t;

	function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] ph);
		logic [COIL_W-1:0] c;
		if (PHASES == 4) begin
			c = FULL_STEPS[ph[1:0]];
		end else begin
			c = HALF_STEPS[ph];
		end
		return c;
	endfunction

	// Pack position, flag, sonar and lidar into the four frame bytes, and carry the coil pattern
	function automatic frame_t pack_frame(
		input logic [POS_W-1:0]   pos,
		input logic               fe,
		input logic [8:0]         sonar,
		input logic [LIDAR_W-1:0] lidar,
		input logic [COIL_W-1:0]  coil
	);
		frame_t f;
		f.bytes[0] = {1'b0, fe, pos};
		f.bytes[1] = {1'b1, sonar[8:2]};
		f.bytes[2] = {1'b1, sonar[1:0], lidar[11:7]};
		f.bytes[3] = {1'b1, lidar[6:0]};
		f.coil     = coil;
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- src/ssfp_store.sv -----
// ----------------------------------------------------------------------------
// ssfp_store
// Four sample slots for sonar and lidar, with the averaging adder trees.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfp_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [ssfp_pkg::SONAR_W-1:0]  sonar_in,
	input  wire logic [ssfp_pkg::LIDAR_W-1:0]  lidar_in,
	input  wire logic                          filter_enable,
	output logic      [ssfp_pkg::SONAR_W-1:0]  sonar_value,
	output logic      [ssfp_pkg::LIDAR_W-1:0]  lidar_value,
	output logic      [ssfp_pkg::SLOT_W-1:0]   slot
);

	logic [ssfp_pkg::SONAR_W-1:0] sonar_q [ssfp_pkg::SAMPLES];
	logic [ssfp_pkg::LIDAR_W-1:0] lidar_q [ssfp_pkg::SAMPLES];
	logic [ssfp_pkg::SLOT_W-1:0]  slot_q;
	logic [ssfp_pkg::SONAR_W-1:0] sonar_sum;
	logic [ssfp_pkg::SONAR_W-1:0] lidar_sum;

	// Slot write and round-robin slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < ssfp_pkg::SAMPLES; i++) begin
				sonar_q[i] <= '0;
				lidar_q[i] <= '0;
			end
		end else if (wr_en) begin
			sonar_q[slot_q] <= sonar_in;
			lidar_q[slot_q] <= lidar_in;
			slot_q          <= ssfp_pkg::SLOT_W'(slot_q + 1'b1);
		end
	end

	// 16-bit wrapping sums over all slots
	always_comb begin
		sonar_sum = '0;
		lidar_sum = '0;
		for (int i = 0; i < ssfp_pkg::SAMPLES; i++) begin
			sonar_sum = ssfp_pkg::SONAR_W'(sonar_sum + sonar_q[i]);
			lidar_sum = ssfp_pkg::SONAR_W'(lidar_sum + {4'b0, lidar_q[i]});
		end
	end

	// Mean of four or slot 0
	assign sonar_value = filter_enable ? {2'b00, sonar_sum[15:2]} : sonar_q[0];
	assign lidar_value = filter_enable ? lidar_sum[13:2] : lidar_q[0];
	assign slot        = slot_q;

endmodule

`default_nettype wire

// ----- src/ssfp_sweep.sv -----
// ----------------------------------------------------------------------------
// ssfp_sweep
// Sweep position, direction and stepper phase with coil pattern lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfp_sweep (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [ssfp_pkg::POS_W-1:0]  position_max,
	output logic      [ssfp_pkg::POS_W-1:0]  position,
	output logic      [ssfp_pkg::COIL_W-1:0] coil
);

	logic [ssfp_pkg::POS_W-1:0]   pos_q;
	logic                         up_q;
	logic [ssfp_pkg::PHASE_W-1:0] phase_q;
	logic [ssfp_pkg::POS_W-1:0]   pos_nxt;
	logic [ssfp_pkg::PHASE_W-1:0] phase_nxt;

	localparam logic [ssfp_pkg::PHASE_W-1:0] PHASE_LAST =
		ssfp_pkg::PHASE_W'(ssfp_pkg::PHASES - 1);

	// Next position and phase in the current direction
	always_comb begin
		if (up_q) begin
			pos_nxt   = ssfp_pkg::POS_W'(pos_q + 1'b1);
			phase_nxt = (phase_q == PHASE_LAST) ? '0 : ssfp_pkg::PHASE_W'(phase_q + 1'b1);
		end else begin
			pos_nxt   = ssfp_pkg::POS_W'(pos_q - 1'b1);
			phase_nxt = (phase_q == '0) ? PHASE_LAST : ssfp_pkg::PHASE_W'(phase_q - 1'b1);
		end
	end

	// Step and reverse on an exact hit of either end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= ssfp_pkg::POS_RESET;
			up_q    <= 1'b1;
			phase_q <= '0;
		end else if (step) begin
			pos_q   <= pos_nxt;
			phase_q <= phase_nxt;
			if (pos_nxt == position_max || pos_nxt == ssfp_pkg::POS_MIN) begin
				up_q <= ~up_q;
			end
		end
	end

	assign position = pos_q;
	assign coil     = ssfp_pkg::coil_of(3'(phase_q));

endmodule

`default_nettype wire

// ----- src/ssfp_frame_out.sv -----
// ----------------------------------------------------------------------------
// ssfp_frame_out
// Frame buffer that sends one frame byte per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfp_frame_out (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire ssfp_pkg::frame_t            frame_in,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic      [ssfp_pkg::BYTE_W-1:0] frame_byte,
	output logic                             last,
	output logic      [ssfp_pkg::COIL_W-1:0] coil_pattern,
	output ssfp_pkg::fout_stat_t             stat
);

	localparam logic [ssfp_pkg::BIDX_W-1:0] IDX_LAST =
		ssfp_pkg::BIDX_W'(ssfp_pkg::FRAME_BYTES - 1);

	ssfp_pkg::frame_t              frame_q;
	logic                          busy_q;
	logic [ssfp_pkg::BIDX_W-1:0]   idx_q;
	logic                          pop;
	logic                          is_last;

	assign is_last = (idx_q == IDX_LAST);
	assign pop     = busy_q && out_ready;

	// Frame payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame_in;
		end
	end

	// Byte pointer and busy flag; a new frame may load as the last byte leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop) begin
			idx_q <= ssfp_pkg::BIDX_W'(idx_q + 1'b1);
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_valid    = busy_q;
	assign frame_byte   = frame_q.bytes[idx_q];
	assign last         = is_last;
	assign coil_pattern = frame_q.coil;

	assign stat.busy = busy_q;
	assign stat.free = !busy_q || (is_last && out_ready);
	assign stat.idx  = idx_q;

endmodule

`default_nettype wire

// ----- src/scan_sweep_frame_packer_top.sv -----
// ----------------------------------------------------------------------------
// scan_sweep_frame_packer_top
// Sweeping range scanner: sample store, stepper sweep and frame serializer.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   func, sonar_sample, lidar_sample
//  out       out_valid / out_ready frame_byte, last, coil_pattern
//  cfg       cfg_we                cfg_index, cfg_data
//
//  Items pass an input register, then execute. A measurement writes a
//  sample slot and gives no output. A move loads a four-byte frame into
//  the output buffer, which sends one byte per cycle while out_ready is
//  high. A move waits in the input register until the buffer is empty or
//  its final byte is leaving in that cycle; measurements behind it wait
//  too. Reset clears all but the payload registers at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_sweep_frame_packer_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            func,
	input  wire logic [ssfp_pkg::SONAR_W-1:0]    sonar_sample,
	input  wire logic [ssfp_pkg::LIDAR_W-1:0]    lidar_sample,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ssfp_pkg::BYTE_W-1:0]     frame_byte,
	output logic                                 last,
	output logic      [ssfp_pkg::COIL_W-1:0]     coil_pattern,
	input  wire logic                            cfg_we,
	input  wire logic [ssfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssfp_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                          filter_enable_q;
	logic [ssfp_pkg::POS_W-1:0]    position_max_q;

	logic                          v_s1;
	ssfp_pkg::func_t               func_s1;
	logic [ssfp_pkg::SONAR_W-1:0]  sonar_s1;
	logic [ssfp_pkg::LIDAR_W-1:0]  lidar_s1;

	logic                          s1_fire;
	logic                          wr_en;
	logic                          load;
	logic [ssfp_pkg::SONAR_W-1:0]  sonar_value;
	logic [ssfp_pkg::LIDAR_W-1:0]  lidar_value;
	logic [ssfp_pkg::SLOT_W-1:0]   slot;
	logic [ssfp_pkg::POS_W-1:0]    position;
	logic [ssfp_pkg::COIL_W-1:0]   coil;
	ssfp_pkg::frame_t              frame;
	ssfp_pkg::fout_stat_t          fstat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b1;
			position_max_q  <= ssfp_pkg::POS_MAX_RESET;
		end else if (cfg_we) begin
			unique case (ssfp_pkg::cfg_reg_t'(cfg_index))
				ssfp_pkg::REG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				ssfp_pkg::REG_POSITION_MAX:  position_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 executes unless a move finds the frame buffer still busy
	assign s1_fire  = v_s1 && (func_s1 == ssfp_pkg::FUNC_MEASURE || fstat.free);
	assign in_ready = !v_s1 || s1_fire;
	assign wr_en    = s1_fire && func_s1 == ssfp_pkg::FUNC_MEASURE;
	assign load     = s1_fire && func_s1 == ssfp_pkg::FUNC_MOVE;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= ssfp_pkg::func_t'(func);
			sonar_s1 <= sonar_sample;
			lidar_s1 <= lidar_sample;
		end
	end

	ssfp_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.sonar_in      (sonar_s1),
		.lidar_in      (lidar_s1),
		.filter_enable (filter_enable_q),
		.sonar_value   (sonar_value),
		.lidar_value   (lidar_value),
		.slot          (slot)
	);

	ssfp_sweep u_sweep (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (load),
		.position_max (position_max_q),
		.position     (position),
		.coil         (coil)
	);

	// Frame assembly from the state before this move steps
	assign frame = ssfp_pkg::pack_frame(position, filter_enable_q, sonar_value[8:0],
		lidar_value, coil);

	ssfp_frame_out u_frame_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.frame_in     (frame),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.frame_byte   (frame_byte),
		.last         (last),
		.coil_pattern (coil_pattern),
		.stat         (fstat)
	);

`ifndef NO_ASSERTIONS
	// A move is only loaded into a buffer that can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> fstat.free)
		else $error("frame loaded while buffer busy");

	// Each move steps the position by exactly one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (position == $past(position) + 6'd1 ||
			position == $past(position) - 6'd1))
		else $error("position did not step by one");

	// Each measurement advances the slot pointer by one
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> slot == $past(slot) + 2'd1)
		else $error("slot pointer did not advance");

	// A frame is never cut short before its last byte
	a_frame_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (out_valid && fstat.idx != '0))
		else $error("frame cut short");
`endif

endmodule

`default_nettype wire
